// File: hdl/acpr_pkg.sv
// package for the bus command pulse receiver
// shared types, register indexes, event codes and reset values; no dependencies
package acpr_pkg;

  localparam int unsigned DUR_W = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ATTN_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTN_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRST_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BRST_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_MAX   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEV_MASK  = 3'd6;

  // register reset values
  localparam logic [DUR_W-1:0] ATTN_MIN_RST  = 16'd776;
  localparam logic [DUR_W-1:0] ATTN_MAX_RST  = 16'd824;
  localparam logic [DUR_W-1:0] BRST_MIN_RST  = 16'd2910;
  localparam logic [DUR_W-1:0] BRST_MAX_RST  = 16'd3090;
  localparam logic [DUR_W-1:0] ONE_LIMIT_RST = 16'd50;
  localparam logic [DUR_W-1:0] BIT_MAX_RST   = 16'd72;
  localparam logic [DUR_W-1:0] DEV_MASK_RST  = 16'd0;

  // event kinds
  localparam logic [1:0] KIND_BUS_RESET     = 2'd0;
  localparam logic [1:0] KIND_INVALID       = 2'd1;
  localparam logic [1:0] KIND_GENERAL_RESET = 2'd2;
  localparam logic [1:0] KIND_ADDRESSED     = 2'd3;

  typedef struct packed {
    logic [DUR_W-1:0] attention_min;
    logic [DUR_W-1:0] attention_max;
    logic [DUR_W-1:0] bus_reset_min;
    logic [DUR_W-1:0] bus_reset_max;
    logic [DUR_W-1:0] one_bit_limit;
    logic [DUR_W-1:0] bit_max;
  } pulse_bounds_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] cmd_byte;
  } bus_event_t;

endpackage

// File: hdl/adb_command_pulse_receiver.sv
// top level of the bus command pulse receiver: config registers, front, queue, back
// depends on acpr_pkg, acpr_front, acpr_queue and acpr_back
// a finished event passes through the queue and then the result register, held until popped
// throughput: one pulse per cycle; in_full stalls input only while the queue is full
// reset: frame returns to idle, queue and result register empty, registers take default bounds
module adb_command_pulse_receiver import acpr_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [DUR_W-1:0]     in_low_duration,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [1:0]           out_event_kind,
  output logic [3:0]           out_device_address,
  output logic [1:0]           out_command_code,
  output logic [1:0]           out_register_number,
  output logic                 out_address_matched,
  output logic [7:0]           out_command_byte,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DUR_W-1:0]     cfg_data
);

  pulse_bounds_t    bounds_r;
  logic [DUR_W-1:0] mask_r;
  logic             ev_valid;
  bus_event_t       ev;
  logic             q_rd;
  logic             q_nonempty;
  bus_event_t       q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bounds_r.attention_min <= ATTN_MIN_RST;
      bounds_r.attention_max <= ATTN_MAX_RST;
      bounds_r.bus_reset_min <= BRST_MIN_RST;
      bounds_r.bus_reset_max <= BRST_MAX_RST;
      bounds_r.one_bit_limit <= ONE_LIMIT_RST;
      bounds_r.bit_max       <= BIT_MAX_RST;
      mask_r                 <= DEV_MASK_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ATTN_MIN:  bounds_r.attention_min <= cfg_data;
        REG_ATTN_MAX:  bounds_r.attention_max <= cfg_data;
        REG_BRST_MIN:  bounds_r.bus_reset_min <= cfg_data;
        REG_BRST_MAX:  bounds_r.bus_reset_max <= cfg_data;
        REG_ONE_LIMIT: bounds_r.one_bit_limit <= cfg_data;
        REG_BIT_MAX:   bounds_r.bit_max       <= cfg_data;
        REG_DEV_MASK:  mask_r                 <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  acpr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (in_push),
    .q_full       (in_full),
    .low_duration (in_low_duration),
    .bounds       (bounds_r),
    .ev_valid     (ev_valid),
    .ev           (ev)
  );

  acpr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (ev_valid),
    .wr_data  (ev),
    .full     (in_full),
    .rd_en    (q_rd),
    .rd_data  (q_data),
    .nonempty (q_nonempty)
  );

  acpr_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_nonempty          (q_nonempty),
    .q_data              (q_data),
    .q_rd                (q_rd),
    .dev_mask            (mask_r),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_event_kind      (out_event_kind),
    .out_device_address  (out_device_address),
    .out_command_code    (out_command_code),
    .out_register_number (out_register_number),
    .out_address_matched (out_address_matched),
    .out_command_byte    (out_command_byte)
  );

endmodule

// File: hdl/acpr_front.sv
// front end: classifies each pulse and tracks the command frame
// depends on acpr_pkg; hands finished events to acpr_queue
module acpr_front import acpr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic             q_full,
  input  logic [DUR_W-1:0] low_duration,
  input  pulse_bounds_t    bounds,
  output logic             ev_valid,
  output bus_event_t       ev
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_BITS = 2'd1;
  localparam logic [1:0] PH_STOP = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] count_r, count_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       accept;
  logic       in_attn, in_brst, is_one, is_long;
  logic [3:0] count_inc;

  assign accept    = push & ~q_full;
  assign in_attn   = (low_duration >= bounds.attention_min) &&
                     (low_duration <= bounds.attention_max);
  assign in_brst   = (low_duration >= bounds.bus_reset_min) &&
                     (low_duration <= bounds.bus_reset_max);
  assign is_one    = low_duration < bounds.one_bit_limit;
  assign is_long   = low_duration > bounds.bit_max;
  assign count_inc = count_r + 4'd1;

  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    shift_nxt   = shift_r;
    ev_valid    = 1'b0;
    ev.kind     = KIND_INVALID;
    ev.cmd_byte = 8'd0;
    if (accept) begin
      case (phase_r)
        PH_BITS: begin
          if (is_long && !is_one) begin
            phase_nxt = PH_IDLE;
            count_nxt = 4'd0;
            ev_valid  = 1'b1;
          end else begin
            shift_nxt = {shift_r[6:0], is_one};
            count_nxt = count_inc;
            if (count_inc >= 4'd8) begin
              phase_nxt = PH_STOP;
            end
          end
        end
        PH_STOP: begin
          phase_nxt   = PH_IDLE;
          count_nxt   = 4'd0;
          ev_valid    = 1'b1;
          ev.cmd_byte = shift_r;
          ev.kind     = (shift_r[3:0] == 4'd0) ? KIND_GENERAL_RESET : KIND_ADDRESSED;
        end
        default: begin
          phase_nxt = PH_IDLE;
          if (in_attn) begin
            phase_nxt = PH_BITS;
            count_nxt = 4'd0;
            shift_nxt = 8'd0;
          end else begin
            ev_valid = 1'b1;
            ev.kind  = in_brst ? KIND_BUS_RESET : KIND_INVALID;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      count_r <= 4'd0;
      shift_r <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      shift_r <= shift_nxt;
    end
  end

endmodule

// File: hdl/acpr_queue.sv
// short event queue between front end and back end
// depends on acpr_pkg for the event type
module acpr_queue import acpr_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  bus_event_t wr_data,
  output logic       full,
  input  logic       rd_en,
  output bus_event_t rd_data,
  output logic       nonempty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  bus_event_t        mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  assign full     = (cnt_r == CNT_FULL);
  assign nonempty = (cnt_r != '0);
  assign do_wr    = wr_en & ~full;
  assign do_rd    = rd_en & nonempty;
  assign rd_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: hdl/acpr_back.sv
// back end: expands queued events into result fields and holds the result
// depends on acpr_pkg; drains acpr_queue
module acpr_back import acpr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_nonempty,
  input  bus_event_t       q_data,
  output logic             q_rd,
  input  logic [DUR_W-1:0] dev_mask,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [1:0]       out_event_kind,
  output logic [3:0]       out_device_address,
  output logic [1:0]       out_command_code,
  output logic [1:0]       out_register_number,
  output logic             out_address_matched,
  output logic [7:0]       out_command_byte
);

  logic       valid_r, valid_nxt;
  logic [1:0] kind_r;
  logic [3:0] addr_r;
  logic [1:0] cmd_r;
  logic [1:0] reg_r;
  logic       hit_r;
  logic [7:0] byte_r;
  logic       is_addr;

  assign q_rd      = q_nonempty & (~valid_r | out_pop);
  assign is_addr   = (q_data.kind == KIND_ADDRESSED);
  assign valid_nxt = q_rd | (valid_r & ~out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (q_rd) begin
      kind_r <= q_data.kind;
      byte_r <= q_data.cmd_byte;
      addr_r <= is_addr ? q_data.cmd_byte[7:4] : 4'd0;
      cmd_r  <= is_addr ? q_data.cmd_byte[3:2] : 2'd0;
      reg_r  <= is_addr ? q_data.cmd_byte[1:0] : 2'd0;
      hit_r  <= is_addr & dev_mask[q_data.cmd_byte[7:4]];
    end
  end

  assign out_empty           = ~valid_r;
  assign out_event_kind      = kind_r;
  assign out_device_address  = addr_r;
  assign out_command_code    = cmd_r;
  assign out_register_number = reg_r;
  assign out_address_matched = hit_r;
  assign out_command_byte    = byte_r;

endmodule

// File: sim/tb_adb_command_pulse_receiver.sv
// testbench for adb_command_pulse_receiver: queued pulse widths are pushed, results popped and
// checked against an in-bench frame decoder across several register settings
// depends on acpr_pkg and the receiver rtl
module tb_adb_command_pulse_receiver;
  timeunit 1ns;
  timeprecision 1ps;
  import acpr_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_BITS, PH_STOP} frame_phase_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] addr;
    logic [1:0] cmd;
    logic [1:0] regn;
    logic       hit;
    logic [7:0] cmd_byte;
  } bus_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  logic [DUR_W-1:0]     in_low_duration = '0;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic [1:0]           out_event_kind;
  logic [3:0]           out_device_address;
  logic [1:0]           out_command_code;
  logic [1:0]           out_register_number;
  logic                 out_address_matched;
  logic [7:0]           out_command_byte;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DUR_W-1:0]     cfg_data = '0;

  adb_command_pulse_receiver dut (.*);

  always #1 clk = ~clk;

  // decoder copy of the block
  pulse_bounds_t    bounds = '{ATTN_MIN_RST, ATTN_MAX_RST, BRST_MIN_RST, BRST_MAX_RST,
                               ONE_LIMIT_RST, BIT_MAX_RST};
  logic [DUR_W-1:0] present_mask = DEV_MASK_RST;
  frame_phase_e     phase = PH_IDLE;
  logic [3:0]       nbits = '0;
  logic [7:0]       shift = '0;

  logic [DUR_W-1:0] pulse_queue[$];
  bus_result_t      due_events[$];
  int               mismatch_count = 0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  bit               hold_sender = 1'b0;

  function automatic void decode_pulse(logic [DUR_W-1:0] d);
    bus_result_t r;
    logic        has_result;
    r = '0;
    has_result = 1'b1;
    case (phase)
      PH_BITS: begin
        if (d > bounds.bit_max && !(d < bounds.one_bit_limit)) begin
          phase = PH_IDLE;
          nbits = '0;
          r.kind = KIND_INVALID;
        end else begin
          shift = {shift[6:0], (d < bounds.one_bit_limit)};
          nbits = nbits + 4'd1;
          if (nbits >= 4'd8) phase = PH_STOP;
          has_result = 1'b0;
        end
      end
      PH_STOP: begin
        phase = PH_IDLE;
        nbits = '0;
        r.cmd_byte = shift;
        if (shift[3:0] == 4'd0) begin
          r.kind = KIND_GENERAL_RESET;
        end else begin
          r.kind = KIND_ADDRESSED;
          r.addr = shift[7:4];
          r.cmd = shift[3:2];
          r.regn = shift[1:0];
          r.hit = present_mask[shift[7:4]];
        end
      end
      default: begin
        phase = PH_IDLE;
        if (bounds.attention_min <= d && d <= bounds.attention_max) begin
          phase = PH_BITS;
          nbits = '0;
          shift = '0;
          has_result = 1'b0;
        end else if (bounds.bus_reset_min <= d && d <= bounds.bus_reset_max) begin
          r.kind = KIND_BUS_RESET;
        end else begin
          r.kind = KIND_INVALID;
        end
      end
    endcase
    if (has_result) due_events.push_back(r);
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    if (mismatch_count < 100)
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // driver: pulse transfers and result pops
  always @(negedge clk) begin
    if (rst_n && !hold_sender && pulse_queue.size() != 0 &&
        $urandom_range(0, 99) >= send_idle_pct) begin
      in_push <= 1'b1;
      in_low_duration <= pulse_queue[0];
    end else begin
      in_push <= 1'b0;
      in_low_duration <= 16'($urandom);
    end
    out_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) begin
      decode_pulse(in_low_duration);
      void'(pulse_queue.pop_front());
    end
  end

  // monitor: result transfers
  always @(posedge clk) begin
    bus_result_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (due_events.size() == 0) begin
        report_mismatch("unexpected result, kind", 16'(out_event_kind), '0);
      end else begin
        want = due_events.pop_front();
        if (out_event_kind !== want.kind)
          report_mismatch("event_kind", 16'(out_event_kind), 16'(want.kind));
        if (out_device_address !== want.addr)
          report_mismatch("device_address", 16'(out_device_address), 16'(want.addr));
        if (out_command_code !== want.cmd)
          report_mismatch("command_code", 16'(out_command_code), 16'(want.cmd));
        if (out_register_number !== want.regn)
          report_mismatch("register_number", 16'(out_register_number), 16'(want.regn));
        if (out_address_matched !== want.hit)
          report_mismatch("address_matched", 16'(out_address_matched), 16'(want.hit));
        if (out_command_byte !== want.cmd_byte)
          report_mismatch("command_byte", 16'(out_command_byte), 16'(want.cmd_byte));
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DUR_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ATTN_MIN:  bounds.attention_min = value;
      REG_ATTN_MAX:  bounds.attention_max = value;
      REG_BRST_MIN:  bounds.bus_reset_min = value;
      REG_BRST_MAX:  bounds.bus_reset_max = value;
      REG_ONE_LIMIT: bounds.one_bit_limit = value;
      REG_BIT_MAX:   bounds.bit_max = value;
      REG_DEV_MASK:  present_mask = value;
      default: ;
    endcase
  endtask

  task automatic apply_settings(int unsigned a_lo, int unsigned a_hi, int unsigned r_lo,
                                int unsigned r_hi, int unsigned one_lim, int unsigned b_max,
                                int unsigned mask);
    write_reg(REG_ATTN_MIN, a_lo[15:0]);
    write_reg(REG_ATTN_MAX, a_hi[15:0]);
    write_reg(REG_BRST_MIN, r_lo[15:0]);
    write_reg(REG_BRST_MAX, r_hi[15:0]);
    write_reg(REG_ONE_LIMIT, one_lim[15:0]);
    write_reg(REG_BIT_MAX, b_max[15:0]);
    write_reg(REG_DEV_MASK, mask[15:0]);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random width in [lo, hi], leaning on the bounds; anything when the range is empty
  function automatic logic [15:0] pick_between(int unsigned lo, int unsigned hi);
    int unsigned sel;
    if (lo > hi) return 16'($urandom);
    sel = $urandom_range(0, 7);
    if (sel == 0) return lo[15:0];
    if (sel == 1) return hi[15:0];
    return 16'(lo + $urandom % (hi - lo + 1));
  endfunction

  function automatic int queue_frame(logic [7:0] cmd_byte, int abort_at);
    int unsigned one_lim;
    int unsigned b_max;
    one_lim = 32'(bounds.one_bit_limit);
    b_max = 32'(bounds.bit_max);
    pulse_queue.push_back(pick_between(32'(bounds.attention_min), 32'(bounds.attention_max)));
    for (int i = 7; i >= 0; i--) begin
      if (i == abort_at) begin
        pulse_queue.push_back((b_max == 65535) ? 16'($urandom) : pick_between(b_max + 1, 65535));
        return 9 - i;
      end
      if (cmd_byte[i])
        pulse_queue.push_back((one_lim == 0) ? 16'($urandom) : pick_between(0, one_lim - 1));
      else
        pulse_queue.push_back(pick_between(one_lim, b_max));
    end
    pulse_queue.push_back(16'($urandom));
    return 10;
  endfunction

  task automatic queue_traffic(int n_items);
    int          added;
    int          sel;
    logic [7:0]  b;
    added = 0;
    while (added < n_items) begin
      sel = $urandom_range(0, 99);
      b = 8'($urandom);
      if ($urandom_range(0, 4) == 0) b[3:0] = 4'd0;
      if (sel < 75) begin
        added += queue_frame(b, -1);
      end else if (sel < 83) begin
        added += queue_frame(b, $urandom_range(0, 7));
      end else if (sel < 90) begin
        pulse_queue.push_back(pick_between(32'(bounds.bus_reset_min),
                                           32'(bounds.bus_reset_max)));
        added++;
      end else begin
        pulse_queue.push_back(16'($urandom));
        added++;
      end
    end
  endtask

  task automatic drain;
    do @(posedge clk); while (pulse_queue.size() != 0 || in_push || due_events.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic run_phase(int n_items, int send_pct, int recv_pct, bit with_pause);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    queue_traffic(n_items);
    if (with_pause) begin
      do @(posedge clk); while (pulse_queue.size() > n_items / 2);
      hold_sender = 1'b1;
      do @(posedge clk); while (in_push || due_events.size() != 0);
      repeat (10) @(posedge clk);
      hold_sender = 1'b0;
    end
    drain();
  endtask

  initial begin
    logic [15:0] directed[];
    int unsigned a_lo;
    int unsigned one_lim;
    directed = '{16'd0, 16'd65535, 16'd775, 16'd2910,
                 16'd776, 16'd49, 16'd0, 16'd50, 16'd72,
                 16'd49, 16'd49, 16'd50, 16'd0, 16'd65535,
                 16'd824, 16'd72, 16'd72, 16'd72, 16'd72,
                 16'd72, 16'd72, 16'd72, 16'd72, 16'd0,
                 16'd800, 16'd49, 16'd3000};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed pulses on reset bounds
    send_idle_pct = 24;
    recv_idle_pct = 85;
    foreach (directed[i]) pulse_queue.push_back(directed[i]);
    drain();

    apply_settings(776, 824, 2910, 3090, 50, 72, $urandom);
    run_phase(600, 24, 85, 1'b1);

    // whole range is attention, no one bits, bit limit at zero
    apply_settings(0, 65535, 100, 200, 0, 0, 16'h0000);
    run_phase(150, 85, 24, 1'b0);

    // inverted attention window, every idle pulse is a bus reset
    apply_settings(1000, 999, 0, 65535, 65535, 0, 16'hFFFF);
    run_phase(60, 85, 24, 1'b0);

    // overlapping windows, bit limits at the top
    apply_settings(700, 3000, 2900, 3100, 65535, 65535, 16'hFFFF);
    run_phase(300, 85, 24, 1'b0);

    a_lo = $urandom_range(100, 1000);
    one_lim = $urandom_range(10, 60);
    apply_settings(a_lo, a_lo + $urandom_range(0, 100), $urandom_range(2500, 3000),
                   $urandom_range(3000, 3500), one_lim, one_lim + $urandom_range(0, 40),
                   $urandom);
    run_phase(400, 0, 0, 1'b0);

    if (mismatch_count == 0)
      $display("** adb_command_pulse_receiver: PASSED **");
    else
      $display("** adb_command_pulse_receiver: FAILED **");
    $finish;
  end

  initial begin
    #1ms;
    $display("** adb_command_pulse_receiver: FAILED **");
    $finish;
  end

endmodule
